### design/snpa_pkg.sv
// ----------------------------------------------------------------------------
// snpa_pkg
// Shared defaults and configuration register indexes for the semiquadratic
// norm penalty block.
// ----------------------------------------------------------------------------
package snpa_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOMINAL_NORM   = 2'd0,
		REG_PENALTY_WEIGHT = 2'd1,
		REG_PENALIZE_ABOVE = 2'd2
	} cfg_reg_t;

endpackage

### design/snpa_isqrt.sv
// ----------------------------------------------------------------------------
// snpa_isqrt
// Pipelined integer square root, one root bit per stage. Returns
// floor(sqrt(radicand)) after W stages and carries a tag alongside.
// ----------------------------------------------------------------------------
module snpa_isqrt #(
	parameter int W     = snpa_pkg::DATA_WIDTH_DEF,
	parameter int TAG_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2*W-1:0]     in_radicand,
	input  logic [TAG_W-1:0]   in_tag,
	output logic               out_valid,
	output logic [W-1:0]       out_root,
	output logic [TAG_W-1:0]   out_tag
);

	logic             vld_s  [W];
	logic [W+1:0]     rem_s  [W];
	logic [W-1:0]     root_s [W];
	logic [2*W-1:0]   rad_s  [W];
	logic [TAG_W-1:0] tag_s  [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic             v_in;
		logic [W+1:0]     rem_in;
		logic [W-1:0]     root_in;
		logic [2*W-1:0]   rad_in;
		logic [TAG_W-1:0] tag_in;
		logic [W+1:0]     cat;
		logic [W+1:0]     trial;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_radicand;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		assign cat   = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k] <= rad_in << 2;
			tag_s[k] <= tag_in;
			if (cat >= trial) begin
				rem_s[k]  <= cat - trial;
				root_s[k] <= {root_in[W-2:0], 1'b1};
			end else begin
				rem_s[k]  <= cat;
				root_s[k] <= {root_in[W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign out_root  = root_s[W-1];
	assign out_tag   = tag_s[W-1];

endmodule

### design/snpa_div.sv
// ----------------------------------------------------------------------------
// snpa_div
// Pipelined restoring divider with a Q_W-bit quotient. An entry stage flags
// quotients of 2^Q_W or more, then one quotient bit is formed per stage.
// ----------------------------------------------------------------------------
module snpa_div #(
	parameter int NUM_W = 3 * snpa_pkg::DATA_WIDTH_DEF,
	parameter int DEN_W = snpa_pkg::DATA_WIDTH_DEF,
	parameter int Q_W   = snpa_pkg::DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	localparam int RW0 = NUM_W - Q_W;
	localparam int CW  = ((RW0 > DEN_W) ? RW0 : DEN_W) + 1;

	logic [DEN_W-1:0] rem_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0]   low_s [Q_W+1];
	logic [Q_W-1:0]   quo_s [Q_W+1];
	logic             ovf_s [Q_W+1];

	always_ff @(posedge clk) begin
		ovf_s[0] <= CW'(num[NUM_W-1:Q_W]) >= CW'(den);
		rem_s[0] <= DEN_W'(num[NUM_W-1:Q_W]);
		den_s[0] <= den;
		low_s[0] <= num[Q_W-1:0];
		quo_s[0] <= '0;
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DEN_W:0] cat;
		logic [DEN_W:0] dext;
		logic           ge;

		assign cat  = {rem_s[k-1], low_s[k-1][Q_W-1]};
		assign dext = {1'b0, den_s[k-1]};
		assign ge   = cat >= dext;

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DEN_W'(cat - dext) : cat[DEN_W-1:0];
			den_s[k] <= den_s[k-1];
			low_s[k] <= low_s[k-1] << 1;
			quo_s[k] <= {quo_s[k-1][Q_W-2:0], ge};
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign quo = quo_s[Q_W];
	assign ovf = ovf_s[Q_W];

endmodule

### design/semiquadratic_norm_penalty.sv
// ----------------------------------------------------------------------------
// semiquadratic_norm_penalty
// One-sided quadratic penalty on the norm of a 2-D point, with gradient and
// Hessian terms, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high (busy stays low), one
// per cycle with no gaps. Each request yields one result, strobed by done for a
// single cycle, in request order. The latency is set by the square root, one
// root bit per stage, and the dividers, one quotient bit per stage. The result
// side cannot be stalled. Write configuration only while no request is in
// flight; the write port is always ready.
// ----------------------------------------------------------------------------
module semiquadratic_norm_penalty #(
	parameter int FRAC_BITS  = snpa_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = snpa_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [DATA_WIDTH-1:0]     coord_a,
	input  logic signed [DATA_WIDTH-1:0]     coord_b,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [snpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [DATA_WIDTH-1:0]            cfg_data,
	output logic                             done,
	output logic [DATA_WIDTH-2:0]            penalty,
	output logic signed [DATA_WIDTH-1:0]     grad_a,
	output logic signed [DATA_WIDTH-1:0]     grad_b,
	output logic signed [DATA_WIDTH-1:0]     hess_aa,
	output logic signed [DATA_WIDTH-1:0]     hess_bb,
	output logic signed [DATA_WIDTH-1:0]     hess_ab,
	output logic                             cost_active,
	output logic                             quad_active,
	output logic                             zero_norm
);

	localparam int DW      = DATA_WIDTH;
	localparam int UW      = DATA_WIDTH - 1;
	localparam int F       = FRAC_BITS;
	localparam int DIV_LAT = DW + 1;
	localparam int GN_W    = 3 * DW - F;
	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [UW-1:0] WEIGHT_RST = UW'(1) << F;

	typedef struct packed {
		logic [DW-1:0]   xm;
		logic [DW-1:0]   ym;
		logic [2*DW-1:0] x2;
		logic [2*DW-1:0] y2;
		logic [2*DW-1:0] xy;
		logic            xneg;
		logic            yneg;
	} sq_tag_t;

	typedef struct packed {
		logic            cost;
		logic            quad;
		logic            zero;
		logic            under;
		logic            xneg;
		logic            yneg;
		logic [3*DW-1:0] pen;
	} side_t;

	function automatic logic [2*DW-1:0] mul2(input logic [DW-1:0] a, input logic [DW-1:0] b);
		return (2*DW)'(a) * (2*DW)'(b);
	endfunction

	function automatic logic [DW-1:0] sat_signed(input logic neg, input logic [DW-1:0] q,
		input logic ovf);
		if (neg) begin
			return (ovf || q > SMIN) ? SMIN : DW'(~q + 1'b1);
		end
		return (ovf || q > SMAX) ? SMAX : q;
	endfunction

	function automatic logic [DW-1:0] diag(input logic [DW-1:0] q, input logic ovf,
		input logic [UW-1:0] w);
		logic [DW-1:0] diff;
		diff = '0;
		if (ovf) begin
			return SMIN;
		end
		if (q > {1'b0, w}) begin
			diff = q - {1'b0, w};
			return (diff > SMIN) ? SMIN : DW'(~diff + 1'b1);
		end
		return {1'b0, w} - q;
	endfunction

	function automatic logic [UW-1:0] pen_sat(input logic [3*DW-1:0] p);
		logic [3*DW-1:0] sh;
		sh = p >> (2 * F + 1);
		return (sh[3*DW-1:UW] != '0) ? '1 : sh[UW-1:0];
	endfunction

	// configuration
	logic [UW-1:0] nom_q;
	logic [UW-1:0] wgt_q;
	logic          above_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q   <= '0;
			wgt_q   <= WEIGHT_RST;
			above_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (snpa_pkg::cfg_reg_t'(cfg_index))
				snpa_pkg::REG_NOMINAL_NORM:   nom_q   <= cfg_data[UW-1:0];
				snpa_pkg::REG_PENALTY_WEIGHT: wgt_q   <= cfg_data[UW-1:0];
				snpa_pkg::REG_PENALIZE_ABOVE: above_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: magnitudes
	logic          v_s1, xneg_s1, yneg_s1;
	logic [DW-1:0] xm_s1, ym_s1, a_u, b_u;

	assign a_u = coord_a;
	assign b_u = coord_b;

	// stage 2: squares and cross product
	logic            v_s2, xneg_s2, yneg_s2;
	logic [DW-1:0]   xm_s2, ym_s2;
	logic [2*DW-1:0] x2_s2, y2_s2, xy_s2;

	// stage 3: radicand
	logic            v_s3;
	logic [2*DW-1:0] rad_s3;
	sq_tag_t         tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		xneg_s1 <= a_u[DW-1];
		yneg_s1 <= b_u[DW-1];
		xm_s1   <= a_u[DW-1] ? DW'(~a_u + 1'b1) : a_u;
		ym_s1   <= b_u[DW-1] ? DW'(~b_u + 1'b1) : b_u;

		xneg_s2 <= xneg_s1;
		yneg_s2 <= yneg_s1;
		xm_s2   <= xm_s1;
		ym_s2   <= ym_s1;
		x2_s2   <= mul2(xm_s1, xm_s1);
		y2_s2   <= mul2(ym_s1, ym_s1);
		xy_s2   <= mul2(xm_s1, ym_s1);

		rad_s3      <= x2_s2 + y2_s2;
		tag_s3.xm   <= xm_s2;
		tag_s3.ym   <= ym_s2;
		tag_s3.x2   <= x2_s2;
		tag_s3.y2   <= y2_s2;
		tag_s3.xy   <= xy_s2;
		tag_s3.xneg <= xneg_s2;
		tag_s3.yneg <= yneg_s2;
	end

	// square root
	logic          v_sq;
	logic [DW-1:0] n_sq;
	sq_tag_t       tag_sq;

	snpa_isqrt #(
		.W     (DW),
		.TAG_W ($bits(sq_tag_t))
	) u_isqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s3),
		.in_radicand (rad_s3),
		.in_tag      (tag_s3),
		.out_valid   (v_sq),
		.out_root    (n_sq),
		.out_tag     (tag_sq)
	);

	// stage 4: side decision and distance
	logic          over, under;
	logic [DW-1:0] t_ext;

	assign t_ext = {1'b0, nom_q};
	assign over  = n_sq > t_ext;
	assign under = n_sq < t_ext;

	logic          v_s4, cost_s4, quad_s4, zero_s4, under_s4;
	logic [DW-1:0] n_s4, d_s4;
	sq_tag_t       tag_s4;

	// stage 5: first products
	logic            v_s5, cost_s5, quad_s5, zero_s5, under_s5;
	logic [DW-1:0]   n_s5, d_s5;
	logic [2*DW-1:0] wd_s5, tw_s5, n2_s5;
	sq_tag_t         tag_s5;

	// stage 6: partial products
	logic            v_s6, cost_s6, quad_s6, zero_s6, under_s6, xneg_s6, yneg_s6;
	logic [DW-1:0]   n_s6;
	logic [2*DW-1:0] pen_lo_s6, pen_hi_s6, ga_lo_s6, ga_hi_s6, gb_lo_s6, gb_hi_s6;
	logic [2*DW-1:0] n3_lo_s6, n3_hi_s6;
	logic [2*DW-1:0] hp_s6 [3][4];
	logic [2*DW-1:0] hop [3];

	assign hop[0] = tag_s5.y2;
	assign hop[1] = tag_s5.x2;
	assign hop[2] = tag_s5.xy;

	// stage 7: numerators and denominators
	logic            v_s7;
	logic [DW-1:0]   n_s7;
	logic [3*DW-1:0] ga_s7, gb_s7, n3_s7;
	logic [4*DW-1:0] hn_s7 [3];
	side_t           side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s4 <= v_sq;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		n_s4     <= n_sq;
		d_s4     <= over ? n_sq - t_ext : t_ext - n_sq;
		cost_s4  <= above_q ? over : under;
		quad_s4  <= (above_q ? !under : !over) && (n_sq != '0);
		zero_s4  <= n_sq == '0;
		under_s4 <= under;
		tag_s4   <= tag_sq;

		n_s5     <= n_s4;
		d_s5     <= d_s4;
		cost_s5  <= cost_s4;
		quad_s5  <= quad_s4;
		zero_s5  <= zero_s4;
		under_s5 <= under_s4;
		tag_s5   <= tag_s4;
		wd_s5    <= mul2({1'b0, wgt_q}, d_s4);
		tw_s5    <= mul2({1'b0, nom_q}, {1'b0, wgt_q});
		n2_s5    <= mul2(n_s4, n_s4);

		n_s6      <= n_s5;
		cost_s6   <= cost_s5;
		quad_s6   <= quad_s5;
		zero_s6   <= zero_s5;
		under_s6  <= under_s5;
		xneg_s6   <= tag_s5.xneg;
		yneg_s6   <= tag_s5.yneg;
		pen_lo_s6 <= mul2(wd_s5[DW-1:0], d_s5);
		pen_hi_s6 <= mul2(wd_s5[2*DW-1:DW], d_s5);
		ga_lo_s6  <= mul2(wd_s5[DW-1:0], tag_s5.xm);
		ga_hi_s6  <= mul2(wd_s5[2*DW-1:DW], tag_s5.xm);
		gb_lo_s6  <= mul2(wd_s5[DW-1:0], tag_s5.ym);
		gb_hi_s6  <= mul2(wd_s5[2*DW-1:DW], tag_s5.ym);
		n3_lo_s6  <= mul2(n2_s5[DW-1:0], n_s5);
		n3_hi_s6  <= mul2(n2_s5[2*DW-1:DW], n_s5);
		for (int j = 0; j < 3; j++) begin
			hp_s6[j][0] <= mul2(tw_s5[DW-1:0], hop[j][DW-1:0]);
			hp_s6[j][1] <= mul2(tw_s5[DW-1:0], hop[j][2*DW-1:DW]);
			hp_s6[j][2] <= mul2(tw_s5[2*DW-1:DW], hop[j][DW-1:0]);
			hp_s6[j][3] <= mul2(tw_s5[2*DW-1:DW], hop[j][2*DW-1:DW]);
		end

		n_s7          <= n_s6;
		ga_s7         <= (3*DW)'(ga_lo_s6) + ((3*DW)'(ga_hi_s6) << DW);
		gb_s7         <= (3*DW)'(gb_lo_s6) + ((3*DW)'(gb_hi_s6) << DW);
		n3_s7         <= (3*DW)'(n3_lo_s6) + ((3*DW)'(n3_hi_s6) << DW);
		side_s7.pen   <= (3*DW)'(pen_lo_s6) + ((3*DW)'(pen_hi_s6) << DW);
		side_s7.cost  <= cost_s6;
		side_s7.quad  <= quad_s6;
		side_s7.zero  <= zero_s6;
		side_s7.under <= under_s6;
		side_s7.xneg  <= xneg_s6;
		side_s7.yneg  <= yneg_s6;
		for (int j = 0; j < 3; j++) begin
			hn_s7[j] <= (4*DW)'(hp_s6[j][0]) + ((4*DW)'(hp_s6[j][1]) << DW)
				+ ((4*DW)'(hp_s6[j][2]) << DW) + ((4*DW)'(hp_s6[j][3]) << (2*DW));
		end
	end

	// dividers
	logic [DW-1:0] ga_q, gb_q;
	logic          ga_ovf, gb_ovf;
	logic [DW-1:0] hq [3];
	logic          hovf [3];

	snpa_div #(.NUM_W(GN_W), .DEN_W(DW), .Q_W(DW)) u_div_ga (
		.clk (clk),
		.num (ga_s7[3*DW-1:F]),
		.den (n_s7),
		.quo (ga_q),
		.ovf (ga_ovf)
	);

	snpa_div #(.NUM_W(GN_W), .DEN_W(DW), .Q_W(DW)) u_div_gb (
		.clk (clk),
		.num (gb_s7[3*DW-1:F]),
		.den (n_s7),
		.quo (gb_q),
		.ovf (gb_ovf)
	);

	for (genvar j = 0; j < 3; j++) begin : g_hdiv
		snpa_div #(.NUM_W(4*DW), .DEN_W(3*DW), .Q_W(DW)) u_div_h (
			.clk (clk),
			.num (hn_s7[j]),
			.den (n3_s7),
			.quo (hq[j]),
			.ovf (hovf[j])
		);
	end

	// side data alongside the dividers
	logic [DIV_LAT-1:0] dv_q;
	side_t              side_q [DIV_LAT];
	side_t              so;

	assign so = side_q[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
			done <= 1'b0;
		end else begin
			dv_q <= {dv_q[DIV_LAT-2:0], v_s7};
			done <= dv_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s7;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// output stage
	always_ff @(posedge clk) begin
		penalty     <= so.cost ? pen_sat(so.pen) : '0;
		grad_a      <= so.quad ? sat_signed(so.xneg != so.under, ga_q, ga_ovf) : '0;
		grad_b      <= so.quad ? sat_signed(so.yneg != so.under, gb_q, gb_ovf) : '0;
		hess_aa     <= so.quad ? diag(hq[0], hovf[0], wgt_q) : '0;
		hess_bb     <= so.quad ? diag(hq[1], hovf[1], wgt_q) : '0;
		hess_ab     <= so.quad ? sat_signed(so.xneg != so.yneg, hq[2], hovf[2]) : '0;
		cost_active <= so.cost;
		quad_active <= so.quad;
		zero_norm   <= so.zero;
	end

	a_zero_flat: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_norm |-> !quad_active)
		else $error("zero norm with active derivatives");

	a_deriv_off: assert property (@(posedge clk) disable iff (!arst_n)
		done && !quad_active |-> grad_a == '0 && grad_b == '0 && hess_aa == '0
			&& hess_bb == '0 && hess_ab == '0)
		else $error("derivative terms nonzero off the closed side");

	a_cost_off: assert property (@(posedge clk) disable iff (!arst_n)
		done && !cost_active |-> penalty == '0)
		else $error("penalty nonzero off the penalized side");

	a_cfg_side: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == snpa_pkg::REG_PENALIZE_ABOVE
			|=> above_q == $past(cfg_data[0]))
		else $error("orientation register not updated");

endmodule

### sim/snpa_checker.sv
// ----------------------------------------------------------------------------
// snpa_checker
// Watches the request, configuration and result ports of the norm penalty
// block, computes each expected result with wide exact integer arithmetic,
// and compares every strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module snpa_checker #(
	parameter int FRAC_BITS  = snpa_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = snpa_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic signed [DATA_WIDTH-1:0]   coord_a,
	input  logic signed [DATA_WIDTH-1:0]   coord_b,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [snpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]          cfg_data,
	input  logic                           done,
	input  logic [DATA_WIDTH-2:0]          penalty,
	input  logic signed [DATA_WIDTH-1:0]   grad_a,
	input  logic signed [DATA_WIDTH-1:0]   grad_b,
	input  logic signed [DATA_WIDTH-1:0]   hess_aa,
	input  logic signed [DATA_WIDTH-1:0]   hess_bb,
	input  logic signed [DATA_WIDTH-1:0]   hess_ab,
	input  logic                           cost_active,
	input  logic                           quad_active,
	input  logic                           zero_norm,
	output int                             fail_count,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [255:0] wide_t;

	typedef struct packed {
		logic [DATA_WIDTH-2:0] pen;
		logic [DATA_WIDTH-1:0] ga;
		logic [DATA_WIDTH-1:0] gb;
		logic [DATA_WIDTH-1:0] haa;
		logic [DATA_WIDTH-1:0] hbb;
		logic [DATA_WIDTH-1:0] hab;
		logic                  cost;
		logic                  quad;
		logic                  zero;
	} penalty_result_t;

	localparam wide_t UMAX = (wide_t'(1) << (DATA_WIDTH - 1)) - 1;
	localparam wide_t NMAX = wide_t'(1) << (DATA_WIDTH - 1);

	logic [DATA_WIDTH-2:0] thresh;
	logic [DATA_WIDTH-2:0] weight;
	logic                  above;
	penalty_result_t       expected_results[$];

	function automatic wide_t isqrt(wide_t s);
		wide_t r;
		wide_t c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (wide_t'(1) << b);
			if (c * c <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat(logic neg, wide_t mag);
		if (neg) begin
			if (mag > NMAX)
				mag = NMAX;
			return DATA_WIDTH'(-mag);
		end
		return DATA_WIDTH'(mag > UMAX ? UMAX : mag);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] diag(wide_t w, wide_t q);
		if (q > w)
			return sat(1'b1, q - w);
		return sat(1'b0, w - q);
	endfunction

	function automatic penalty_result_t predict_penalty(logic [DATA_WIDTH-1:0] x,
			logic [DATA_WIDTH-1:0] y);
		penalty_result_t r;
		logic  xn;
		logic  yn;
		wide_t xm;
		wide_t ym;
		wide_t n;
		wide_t t;
		wide_t w;
		wide_t d;
		wide_t n3;
		wide_t den;
		wide_t p;
		logic  over;
		logic  under;
		logic  closed;
		xn = x[DATA_WIDTH-1];
		yn = y[DATA_WIDTH-1];
		xm = xn ? wide_t'(DATA_WIDTH'(-x)) : wide_t'(x);
		ym = yn ? wide_t'(DATA_WIDTH'(-y)) : wide_t'(y);
		if (xm == 0 && xn)
			xm = NMAX;
		if (ym == 0 && yn)
			ym = NMAX;
		t = wide_t'(thresh);
		w = wide_t'(weight);
		n = isqrt(xm * xm + ym * ym);
		over = n > t;
		under = n < t;
		closed = above ? !under : !over;
		d = over ? n - t : t - n;
		r = '0;
		r.cost = above ? over : under;
		r.zero = n == 0;
		r.quad = closed && !r.zero;
		if (r.cost) begin
			p = (w * d * d) >> (2 * FRAC_BITS + 1);
			r.pen = (DATA_WIDTH-1)'(p > UMAX ? UMAX : p);
		end
		if (r.quad) begin
			den = n << FRAC_BITS;
			n3 = n * n * n;
			r.ga = sat(xn != under, (w * d * xm) / den);
			r.gb = sat(yn != under, (w * d * ym) / den);
			r.haa = diag(w, (t * w * ym * ym) / n3);
			r.hbb = diag(w, (t * w * xm * xm) / n3);
			r.hab = sat(xn != yn, (t * w * xm * ym) / n3);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		penalty_result_t e;
		if (!arst_n) begin
			thresh <= '0;
			weight <= (DATA_WIDTH-1)'(1) << FRAC_BITS;
			above <= 1'b1;
			fail_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 64'(penalty), 64'(0));
				end else begin
					e = expected_results.pop_front();
					if (penalty !== e.pen)
						report_mismatch("penalty", 64'(penalty), 64'(e.pen));
					if (grad_a !== e.ga)
						report_mismatch("grad_a", 64'(grad_a), 64'(e.ga));
					if (grad_b !== e.gb)
						report_mismatch("grad_b", 64'(grad_b), 64'(e.gb));
					if (hess_aa !== e.haa)
						report_mismatch("hess_aa", 64'(hess_aa), 64'(e.haa));
					if (hess_bb !== e.hbb)
						report_mismatch("hess_bb", 64'(hess_bb), 64'(e.hbb));
					if (hess_ab !== e.hab)
						report_mismatch("hess_ab", 64'(hess_ab), 64'(e.hab));
					if (cost_active !== e.cost)
						report_mismatch("cost_active", 64'(cost_active), 64'(e.cost));
					if (quad_active !== e.quad)
						report_mismatch("quad_active", 64'(quad_active), 64'(e.quad));
					if (zero_norm !== e.zero)
						report_mismatch("zero_norm", 64'(zero_norm), 64'(e.zero));
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_penalty(coord_a, coord_b));
			pending = expected_results.size();
			if (cfg_valid && cfg_ready) begin
				unique case (snpa_pkg::cfg_reg_t'(cfg_index))
					snpa_pkg::REG_NOMINAL_NORM:   thresh <= cfg_data[DATA_WIDTH-2:0];
					snpa_pkg::REG_PENALTY_WEIGHT: weight <= cfg_data[DATA_WIDTH-2:0];
					snpa_pkg::REG_PENALIZE_ABOVE: above <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives directed and random points through the norm penalty block under
// several threshold, weight and side settings, with and without random request
// gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = snpa_pkg::DATA_WIDTH_DEF;
	localparam int LATENCY = 2 * DW + 8;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic signed [DW-1:0]           coord_a;
	logic signed [DW-1:0]           coord_b;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [snpa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [DW-1:0]                  cfg_data;
	logic                           done;
	logic [DW-2:0]                  penalty;
	logic signed [DW-1:0]           grad_a;
	logic signed [DW-1:0]           grad_b;
	logic signed [DW-1:0]           hess_aa;
	logic signed [DW-1:0]           hess_bb;
	logic signed [DW-1:0]           hess_ab;
	logic                           cost_active;
	logic                           quad_active;
	logic                           zero_norm;
	int                             fail_count;
	int                             pending;

	semiquadratic_norm_penalty uut (.*);

	snpa_checker chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic write_reg(snpa_pkg::cfg_reg_t idx, logic [DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic send_point(logic [DW-1:0] x, logic [DW-1:0] y, bit gaps);
		while (gaps && $urandom_range(99) < 32) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		coord_a <= x;
		coord_b <= y;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic logic [DW-1:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return DW'($signed($urandom_range(2000000)) - 1000000);
			2: return DW'($signed($urandom_range(65536 * 64)) - 65536 * 32);
			3: return {DW{1'($urandom_range(1))}} ^ DW'($urandom_range(3));
			default: return DW'($signed($urandom) >>> $urandom_range(20));
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_norm();
		case ($urandom_range(3))
			0: return 0;
			1: return $urandom_range(65536 * 64);
			2: return $urandom >> 1;
			default: return $urandom_range(65536 * 4);
		endcase
	endfunction

	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [DW-1:0] pts[20][2];
		arst_n = 1'b0;
		start = 1'b0;
		coord_a = '0;
		coord_b = '0;
		cfg_valid = 1'b0;
		cfg_index = snpa_pkg::REG_NOMINAL_NORM;
		cfg_data = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		pts = '{'{0, 0}, '{32'h7fffffff, 32'h7fffffff}, '{32'h80000000, 32'h80000000},
			'{32'h80000000, 32'h7fffffff}, '{32'h00010000, 0}, '{0, 32'hffff0000},
			'{32'h00030000, 32'h00040000}, '{32'hfffd0000, 32'h00040000},
			'{32'h00020000, 0}, '{1, 0}, '{32'hffffffff, 32'hffffffff},
			'{32'h00050000, 32'hfff40000}, '{32'h00001000, 32'h00002000},
			'{32'h80000000, 0}, '{0, 32'h7fffffff}, '{32'h55555555, 32'haaaaaaaa},
			'{32'haaaaaaaa, 32'h55555555}, '{32'h00100000, 32'hfff00000},
			'{32'h00000001, 32'hffffffff}, '{32'h00020000, 32'h00000001}};
		foreach (pts[i])
			send_point(pts[i][0], pts[i][1], 1'b0);
		drain();
		write_reg(snpa_pkg::REG_NOMINAL_NORM, 32'h00020000);
		write_reg(snpa_pkg::REG_PENALTY_WEIGHT, 32'h7fffffff);
		write_reg(snpa_pkg::REG_PENALIZE_ABOVE, 0);
		foreach (pts[i])
			send_point(pts[i][0], pts[i][1], 1'b1);
		drain();
		for (int phase = 0; phase < 16; phase++) begin
			write_reg(snpa_pkg::REG_NOMINAL_NORM, phase == 1 ? 32'h7fffffff : rand_norm());
			write_reg(snpa_pkg::REG_PENALTY_WEIGHT, phase == 2 ? 0 :
				phase == 3 ? 32'h7fffffff : $urandom_range(65536 * 8));
			write_reg(snpa_pkg::REG_PENALIZE_ABOVE, $urandom_range(1));
			for (int k = 0; k < 48; k++)
				send_point(rand_coord(), rand_coord(), phase % 4 != 3);
			drain();
		end
		repeat (LATENCY + 20)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
